// File: rtl/core/ipfd_pkg.sv
// Package with the shared types, constants and key lookup of the IR pulse frame decoder.
package ipfd_pkg;

    localparam int TIME_W = 16;
    localparam int CODE_W = 16;
    localparam int KEY_W = 4;
    localparam int KEY_COUNT = 10;
    localparam int CFG_ADDR_W = 3;

    localparam logic [CFG_ADDR_W-1:0] REG_GAP_LIMIT = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_ZERO_MIN = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_ZERO_MAX = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_ONE_MIN = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_ONE_MAX = 3'd4;

    localparam logic [TIME_W-1:0] GAP_LIMIT_RST = 16'd20000;
    localparam logic [TIME_W-1:0] ZERO_MIN_RST = 16'd600;
    localparam logic [TIME_W-1:0] ZERO_MAX_RST = 16'd800;
    localparam logic [TIME_W-1:0] ONE_MIN_RST = 16'd1300;
    localparam logic [TIME_W-1:0] ONE_MAX_RST = 16'd1500;

    localparam logic [CODE_W-1:0] KEY_CODES [KEY_COUNT] = '{
        16'd255, 16'd32895, 16'd16575, 16'd49215, 16'd8415,
        16'd41055, 16'd24735, 16'd57375, 16'd4335, 16'd36975
    };

    typedef enum logic [1:0] {
        CLS_ZERO    = 2'd0,
        CLS_ONE     = 2'd1,
        CLS_NEITHER = 2'd2
    } bit_class_t;

    typedef struct packed {
        logic [TIME_W-1:0] gap_limit;
        logic [TIME_W-1:0] zero_min;
        logic [TIME_W-1:0] zero_max;
        logic [TIME_W-1:0] one_min;
        logic [TIME_W-1:0] one_max;
    } ipfd_cfg_t;

    typedef struct packed {
        logic [CODE_W-1:0] frame_code;
        logic              key_found;
        logic [KEY_W-1:0]  key_number;
        logic              bad_bit;
    } ipfd_result_t;

    typedef struct packed {
        logic fire;
        logic frame_end;
    } ipfd_status_t;

    typedef struct packed {
        logic             found;
        logic [KEY_W-1:0] number;
    } ipfd_key_t;

    function automatic ipfd_key_t key_lookup(input logic [CODE_W-1:0] code);
        ipfd_key_t res;
        res.found = 1'b0;
        res.number = '0;
        for (int k = KEY_COUNT - 1; k >= 0; k--) begin
            if (code == KEY_CODES[k]) begin
                res.found = 1'b1;
                res.number = KEY_W'(k);
            end
        end
        return res;
    endfunction

endpackage

// File: rtl/core/ir_pulse_frame_decoder.sv
// Top level of the IR pulse frame decoder: stream ports, configuration and output register.
// A frame result passes from the input register through the output register to m_tvalid
// once the output register is free.
// Throughput: one input transaction per cycle; a timestamp that ends a frame waits in the
// input register while the output register still holds a result that was not taken.
// Reset (aresetn low, synchronous) clears both valid flags, the frame state, marks every
// bit position as neither and loads the window registers with their default values.
module ir_pulse_frame_decoder
    import ipfd_pkg::*;
#(
    parameter int CODE_BITS = 16,
    parameter int FIRST_BIT_INTERVAL = 18,
    parameter int LAST_INTERVAL = 33
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [15:0]           s_tdata,   // capture_time[15:0]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [23:0]           m_tdata,   // frame_code[15:0], key_found[16],
                                             // key_number[20:17], bad_bit[21], zero[23:22]
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [TIME_W-1:0]     cfg_wr_data
);

    ipfd_cfg_t         cfg_reg;
    ipfd_cfg_t         cfg_next;
    logic              in_vld_reg;
    logic              in_vld_next;
    logic [TIME_W-1:0] in_data_reg;
    logic [TIME_W-1:0] in_data_next;
    logic              out_vld_reg;
    logic              out_vld_next;
    ipfd_result_t      out_data_reg;
    ipfd_result_t      out_data_next;

    logic         out_free;
    ipfd_status_t status;
    ipfd_result_t result;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_addr)
                REG_GAP_LIMIT: cfg_next.gap_limit = cfg_wr_data;
                REG_ZERO_MIN:  cfg_next.zero_min = cfg_wr_data;
                REG_ZERO_MAX:  cfg_next.zero_max = cfg_wr_data;
                REG_ONE_MIN:   cfg_next.one_min = cfg_wr_data;
                REG_ONE_MAX:   cfg_next.one_max = cfg_wr_data;
                default: ;
            endcase
        end
    end

    assign out_free = !out_vld_reg || m_tready;
    assign s_tready = !in_vld_reg || status.fire;

    ipfd_core #(
        .CODE_BITS          (CODE_BITS),
        .FIRST_BIT_INTERVAL (FIRST_BIT_INTERVAL),
        .LAST_INTERVAL      (LAST_INTERVAL)
    ) u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .item_vld     (in_vld_reg),
        .capture_time (in_data_reg),
        .out_free     (out_free),
        .cfg          (cfg_reg),
        .status       (status),
        .result       (result)
    );

    always_comb begin
        in_vld_next = in_vld_reg;
        in_data_next = in_data_reg;
        if (s_tvalid && s_tready) begin
            in_vld_next = 1'b1;
            in_data_next = s_tdata;
        end else if (status.fire) begin
            in_vld_next = 1'b0;
        end
    end

    always_comb begin
        out_vld_next = out_vld_reg;
        out_data_next = out_data_reg;
        if (status.fire && status.frame_end) begin
            out_vld_next = 1'b1;
            out_data_next = result;
        end else if (m_tready) begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.gap_limit <= GAP_LIMIT_RST;
            cfg_reg.zero_min <= ZERO_MIN_RST;
            cfg_reg.zero_max <= ZERO_MAX_RST;
            cfg_reg.one_min <= ONE_MIN_RST;
            cfg_reg.one_max <= ONE_MAX_RST;
            in_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            cfg_reg <= cfg_next;
            in_vld_reg <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_data_reg <= in_data_next;
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata = {2'b00, out_data_reg.bad_bit, out_data_reg.key_number,
                      out_data_reg.key_found, out_data_reg.frame_code};

    assert property (@(posedge aclk) disable iff (!aresetn)
        (status.fire && status.frame_end) |=> m_tvalid)
        else $error("Frame end did not load the output register.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[16]) |-> (m_tdata[20:17] == '0))
        else $error("Key number is nonzero without a key match.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[20:17] < KEY_W'(KEY_COUNT)))
        else $error("Key number is out of range.");

    assert property (@(posedge aclk)
        !aresetn |=> (!m_tvalid && s_tready))
        else $error("Valid flags were not cleared by reset.");

endmodule

// File: rtl/core/ipfd_classify.sv
// Window classifier that sorts one interval into zero, one or neither.
module ipfd_classify
    import ipfd_pkg::*;
(
    input  logic [TIME_W-1:0] delta,
    input  ipfd_cfg_t         cfg,
    output bit_class_t        bit_class
);

    logic in_zero;
    logic in_one;

    assign in_zero = (delta > cfg.zero_min) && (delta < cfg.zero_max);
    assign in_one = (delta > cfg.one_min) && (delta < cfg.one_max);

    always_comb begin
        if (in_zero) begin
            bit_class = CLS_ZERO;
        end else if (in_one) begin
            bit_class = CLS_ONE;
        end else begin
            bit_class = CLS_NEITHER;
        end
    end

endmodule

// File: rtl/core/ipfd_core.sv
// Frame state, interval counting, bit class store and code assembly of the decoder.
module ipfd_core
    import ipfd_pkg::*;
#(
    parameter int CODE_BITS = 16,
    parameter int FIRST_BIT_INTERVAL = 18,
    parameter int LAST_INTERVAL = 33
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              item_vld,
    input  logic [TIME_W-1:0] capture_time,
    input  logic              out_free,
    input  ipfd_cfg_t         cfg,
    output ipfd_status_t      status,
    output ipfd_result_t      result
);

    localparam int CNT_W = $clog2(LAST_INTERVAL + 2);
    localparam int REL_W = $clog2(LAST_INTERVAL + FIRST_BIT_INTERVAL + CODE_BITS + 2) + 1;
    localparam int IDX_W = (CODE_BITS > 1) ? $clog2(CODE_BITS) : 1;

    logic [TIME_W-1:0] last_capture_reg;
    logic [TIME_W-1:0] last_capture_next;
    logic [CNT_W-1:0]  interval_count_reg;
    logic [CNT_W-1:0]  interval_count_next;
    bit_class_t        bit_class_reg [CODE_BITS];
    bit_class_t        bit_class_next [CODE_BITS];

    logic [TIME_W-1:0]    delta;
    bit_class_t           delta_class;
    logic                 frame_end;
    logic                 fire;
    logic [REL_W-1:0]     count_rel;
    logic                 in_window;
    logic [IDX_W-1:0]     wr_idx;
    logic [CODE_BITS-1:0] code_full;
    logic [CODE_W-1:0]    code_out;
    logic                 bad;
    ipfd_key_t            key;

    assign delta = capture_time - last_capture_reg;

    ipfd_classify u_classify (
        .delta     (delta),
        .cfg       (cfg),
        .bit_class (delta_class)
    );

    assign frame_end = (interval_count_reg > CNT_W'(LAST_INTERVAL)) ||
                       ((delta > cfg.gap_limit) && (interval_count_reg > CNT_W'(2)));
    assign fire = item_vld && (!frame_end || out_free);

    assign count_rel = REL_W'(interval_count_reg);
    assign in_window = (count_rel >= REL_W'(FIRST_BIT_INTERVAL)) &&
                       (count_rel < REL_W'(FIRST_BIT_INTERVAL + CODE_BITS));
    assign wr_idx = IDX_W'(count_rel - REL_W'(FIRST_BIT_INTERVAL));

    always_comb begin
        last_capture_next = last_capture_reg;
        interval_count_next = interval_count_reg;
        for (int k = 0; k < CODE_BITS; k++) begin
            bit_class_next[k] = bit_class_reg[k];
        end
        if (fire) begin
            if (frame_end) begin
                interval_count_next = '0;
            end else begin
                if (in_window) begin
                    bit_class_next[wr_idx] = delta_class;
                end
                interval_count_next = interval_count_reg + CNT_W'(1);
                last_capture_next = capture_time;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_capture_reg <= '0;
            interval_count_reg <= '0;
            for (int k = 0; k < CODE_BITS; k++) begin
                bit_class_reg[k] <= CLS_NEITHER;
            end
        end else begin
            last_capture_reg <= last_capture_next;
            interval_count_reg <= interval_count_next;
            for (int k = 0; k < CODE_BITS; k++) begin
                bit_class_reg[k] <= bit_class_next[k];
            end
        end
    end

    // The first position is the most significant bit of the code.
    always_comb begin
        bad = 1'b0;
        for (int k = 0; k < CODE_BITS; k++) begin
            code_full[CODE_BITS-1-k] = (bit_class_reg[k] == CLS_ONE);
            if ((bit_class_reg[k] != CLS_ONE) && (bit_class_reg[k] != CLS_ZERO)) begin
                bad = 1'b1;
            end
        end
    end

    generate
        if (CODE_BITS >= CODE_W) begin : g_code_trunc
            assign code_out = code_full[CODE_W-1:0];
        end else begin : g_code_ext
            assign code_out = {{(CODE_W - CODE_BITS){1'b0}}, code_full};
        end
    endgenerate

    assign key = key_lookup(code_out);

    assign status.fire = fire;
    assign status.frame_end = frame_end;

    assign result.frame_code = code_out;
    assign result.key_found = key.found;
    assign result.key_number = key.number;
    assign result.bad_bit = bad;

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of the IR pulse frame decoder with its own frame predictor.
module tb;
    import ipfd_pkg::*;

    localparam int FRAME_INTERVALS = 34;
    localparam int BIT_START = 18;
    localparam int BITS = 16;
    localparam int DRAIN_CYCLES = 8;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int MAX_REPORTS = 10;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [15:0]           s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [23:0]           m_tdata;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [TIME_W-1:0]     cfg_wr_data = '0;

    ipfd_cfg_t         windows;
    logic [TIME_W-1:0] prev_capture;
    int unsigned       held_intervals;
    bit_class_t        pos_class [BITS];
    ipfd_result_t      expected_frames [$];
    logic [15:0]       pending_captures [$];
    logic [15:0]       gen_now;
    int                send_idle_pct = 0;
    int                recv_stall_pct = 0;
    logic              recv_hold = 1'b0;
    logic              long_hold_go = 1'b0;
    int                mismatches = 0;

    ir_pulse_frame_decoder DUT (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en),
        .cfg_addr(cfg_addr),
        .cfg_wr_data(cfg_wr_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic bit_class_t window_class(input logic [15:0] d);
        if (d > windows.zero_min && d < windows.zero_max) return CLS_ZERO;
        if (d > windows.one_min && d < windows.one_max) return CLS_ONE;
        return CLS_NEITHER;
    endfunction

    // Advances the frame state by one timestamp and records the frame result it ends.
    task automatic decode_edge(input logic [15:0] now);
        logic [15:0]  delta;
        ipfd_result_t r;
        delta = now - prev_capture;
        if (held_intervals >= FRAME_INTERVALS ||
            (delta > windows.gap_limit && held_intervals > 2)) begin
            held_intervals = 0;
            r = '0;
            for (int k = 0; k < BITS; k++) begin
                r.frame_code = {r.frame_code[CODE_W-2:0], pos_class[k] == CLS_ONE};
                if (pos_class[k] == CLS_NEITHER) r.bad_bit = 1'b1;
            end
            for (int k = KEY_COUNT - 1; k >= 0; k--) begin
                if (r.frame_code == KEY_CODES[k]) begin
                    r.key_found = 1'b1;
                    r.key_number = KEY_W'(k);
                end
            end
            expected_frames.push_back(r);
        end else begin
            if (held_intervals >= BIT_START && held_intervals < BIT_START + BITS)
                pos_class[held_intervals - BIT_START] = window_class(delta);
            held_intervals++;
            prev_capture = now;
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && (!s_tvalid || s_tready)) begin
            if (s_tvalid) decode_edge(s_tdata);
            if (pending_captures.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                s_tvalid <= 1'b1;
                s_tdata <= pending_captures.pop_front();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin : result_monitor
        ipfd_result_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (expected_frames.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("unexpected frame result: tdata %h", m_tdata);
                end else begin
                    want = expected_frames.pop_front();
                    if (m_tdata[15:0] != want.frame_code || m_tdata[16] != want.key_found ||
                        m_tdata[20:17] != want.key_number || m_tdata[21] != want.bad_bit) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display({"frame mismatch: expected code %h found %b key %0d ",
                                      "bad %b, got code %h found %b key %0d bad %b"},
                                     want.frame_code, want.key_found, want.key_number,
                                     want.bad_bit, m_tdata[15:0], m_tdata[16],
                                     m_tdata[20:17], m_tdata[21]);
                    end
                end
            end
            m_tready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // The receiver stays stalled for a long stretch once the stimulus asks for it.
    initial begin
        wait (long_hold_go);
        @(posedge aclk);
        recv_hold <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge aclk);
        recv_hold <= 1'b0;
    end

    initial begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [15:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wr_data <= val;
        case (idx)
            REG_GAP_LIMIT: windows.gap_limit = val;
            REG_ZERO_MIN:  windows.zero_min = val;
            REG_ZERO_MAX:  windows.zero_max = val;
            REG_ONE_MIN:   windows.one_min = val;
            REG_ONE_MAX:   windows.one_max = val;
            default: ;
        endcase
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_windows(input logic [15:0] gap, input logic [15:0] zmin,
                               input logic [15:0] zmax, input logic [15:0] omin,
                               input logic [15:0] omax);
        write_reg(REG_GAP_LIMIT, gap);
        write_reg(REG_ZERO_MIN, zmin);
        write_reg(REG_ZERO_MAX, zmax);
        write_reg(REG_ONE_MIN, omin);
        write_reg(REG_ONE_MAX, omax);
    endtask

    // Waits until no transaction is offered or outstanding, then lets the pipeline drain.
    task automatic settle();
        while (pending_captures.size() != 0 || s_tvalid || expected_frames.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic queue_interval(input logic [15:0] delta);
        gen_now = gen_now + delta;
        pending_captures.push_back(gen_now);
    endtask

    // Returns a value strictly inside the window, or any value when the window is empty.
    function automatic logic [15:0] pick_inside(input logic [15:0] lo, input logic [15:0] hi);
        if (int'(hi) > int'(lo) + 1) return 16'($urandom_range(int'(hi) - 1, int'(lo) + 1));
        return 16'($urandom);
    endfunction

    task automatic queue_frame(input bit full_length);
        logic [15:0] code;
        int          held;
        code = ($urandom_range(99) < 70) ? KEY_CODES[$urandom_range(KEY_COUNT - 1)]
                                         : 16'($urandom);
        held = full_length ? FRAME_INTERVALS : $urandom_range(FRAME_INTERVALS - 1, 3);
        for (int n = 0; n < held; n++) begin
            if (n == 0) begin
                queue_interval(16'($urandom));
            end else if (n >= BIT_START && n < BIT_START + BITS && $urandom_range(99) >= 3) begin
                if (code[BITS - 1 - (n - BIT_START)])
                    queue_interval(pick_inside(windows.one_min, windows.one_max));
                else
                    queue_interval(pick_inside(windows.zero_min, windows.zero_max));
            end else begin
                queue_interval(16'($urandom_range(windows.gap_limit, 0)));
            end
        end
        if (!full_length && windows.gap_limit != 16'hFFFF)
            queue_interval(16'($urandom_range(16'hFFFF, int'(windows.gap_limit) + 1)));
        else
            queue_interval(16'($urandom));
    endtask

    task automatic run_phase(input int send_pct, input int stall_pct, input int frames,
                             input int full_pct);
        send_idle_pct = send_pct;
        recv_stall_pct = stall_pct;
        for (int f = 0; f < frames; f++) begin
            if ($urandom_range(99) < 10)
                repeat ($urandom_range(3, 1)) queue_interval(16'($urandom));
            queue_frame($urandom_range(99) < full_pct);
        end
        settle();
    endtask

    initial begin
        logic [15:0] directed [];
        logic [15:0] zmin;
        logic [15:0] omin;
        directed = '{16'h0000, 16'hFFFF, 16'h0000, 16'h8000,
                     16'd20000, 16'd40000, 16'd60000, 16'd14464, 16'd34465};
        windows = '{GAP_LIMIT_RST, ZERO_MIN_RST, ZERO_MAX_RST, ONE_MIN_RST, ONE_MAX_RST};
        prev_capture = '0;
        held_intervals = 0;
        foreach (pos_class[k]) pos_class[k] = CLS_NEITHER;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Timer wrap, short frames with untouched positions, and a gap equal to and one
        // above the limit.
        foreach (directed[i]) pending_captures.push_back(directed[i]);
        gen_now = directed[directed.size() - 1];
        settle();

        run_phase(0, 0, 2, 40);
        run_phase(80, 0, 2, 40);

        set_windows(16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_phase(0, 80, 2, 100);

        // Overlapping windows, where the zero window takes precedence.
        set_windows(16'd20000, 16'd500, 16'd1500, 16'd700, 16'd2000);
        for (int i = REG_ONE_MAX + 1; i < 2 ** CFG_ADDR_W; i++)
            write_reg(CFG_ADDR_W'(i), 16'($urandom));
        run_phase(6, 6, 2, 50);

        set_windows(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        long_hold_go = 1'b1;
        run_phase(0, 0, 3, 0);

        zmin = 16'($urandom_range(900, 100));
        omin = 16'($urandom_range(2500, 1000));
        set_windows(16'($urandom_range(30000, 5000)), zmin, zmin + 16'($urandom_range(600, 2)),
                    omin, omin + 16'($urandom_range(800, 2)));
        run_phase(80, 80, 2, 40);

        set_windows(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        run_phase(6, 6, 2, 50);

        set_windows(GAP_LIMIT_RST, ZERO_MIN_RST, ZERO_MAX_RST, ONE_MIN_RST, ONE_MAX_RST);
        run_phase(0, 0, 1, 40);

        if (mismatches == 0 && expected_frames.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
